### rtl/optimal_replacement_oracle_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the optimal replacement oracle
// Shared property forms, reset-qualified, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef OPTIMAL_REPLACEMENT_ORACLE_DEFINES_SVH
`define OPTIMAL_REPLACEMENT_ORACLE_DEFINES_SVH

// same-cycle implication
`define ORO_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ORO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/oro_pkg.sv
// ----------------------------------------------------------------------------
// Optimal replacement oracle package
// Default sizes, field widths and reset values shared by the block.
// ----------------------------------------------------------------------------
package oro_pkg;

    localparam int SETS_DEFAULT     = 64;
    localparam int HISTORY_DEFAULT  = 128;
    localparam int MAX_WAYS_DEFAULT = 16;

    localparam int SET_NUMBER_W   = 6;
    localparam int LINE_ADDRESS_W = 64;
    localparam int WAYS_W         = 5;

    localparam logic [WAYS_W-1:0] WAYS_RESET = 5'd16;

endpackage

### rtl/oro_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module oro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/optimal_replacement_oracle.sv
// ----------------------------------------------------------------------------
// Optimal replacement oracle
// Per-set OPTgen: reuse search over an address ring and occupancy update.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  in       | in_valid / in_ready  | set_number, line_address
//  out      | out_valid / out_ready| optimal_hit
//  cfg      | cfg_we               | cfg_wdata (ways_in_use)
//
//  One word at a time: pointer read, scan (1 .. HISTORY-1 ring reads, stops at
//  the reuse), increment (reuse distance, on a hit only), then write-back.
//  Scan and increment step through the ring over the single read port of its RAM.
//  After reset a pass clears all SETS * 2**clog2(HISTORY) ring entries;
//  in_ready stays low during it, cfg writes are taken.
//  A result waiting on out_ready does not block the next input word.
// ----------------------------------------------------------------------------
module optimal_replacement_oracle
    import oro_pkg::*;
#(
    parameter int SETS     = SETS_DEFAULT,
    parameter int HISTORY  = HISTORY_DEFAULT,
    parameter int MAX_WAYS = MAX_WAYS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [SET_NUMBER_W-1:0]   set_number,
    input  logic [LINE_ADDRESS_W-1:0] line_address,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      optimal_hit,
    input  logic                      cfg_we,
    input  logic [WAYS_W-1:0]         cfg_wdata
);

    localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SLOT_W     = $clog2(HISTORY);
    localparam int OCC_W      = $clog2(MAX_WAYS + 1);
    localparam int RING_DEPTH = SETS << SLOT_W;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int ENTRY_W    = 1 + OCC_W + LINE_ADDRESS_W;

    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(HISTORY - 1);
    localparam logic [RING_AW-1:0] CLR_LAST  = RING_AW'(RING_DEPTH - 1);

    typedef struct packed {
        logic                      valid;
        logic [OCC_W-1:0]          occ;
        logic [LINE_ADDRESS_W-1:0] addr;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PTR,
        ST_SCAN,
        ST_INC,
        ST_FINISH,
        ST_DONE
    } state_t;

    function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_LAST : SLOT_W'(s - SLOT_W'(1));
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : SLOT_W'(s + SLOT_W'(1));
    endfunction

    function automatic logic [RING_AW-1:0] ring_index(input logic [SET_W-1:0] s,
                                                      input logic [SLOT_W-1:0] t);
        return RING_AW'({s, t});
    endfunction

    state_t                    state_reg,       state_next;
    logic [RING_AW-1:0]        clr_cnt_reg,     clr_cnt_next;
    logic [SET_W-1:0]          set_reg,         set_next;
    logic [LINE_ADDRESS_W-1:0] addr_reg,        addr_next;
    logic [WAYS_W-1:0]         limit_reg,       limit_next;
    logic [SLOT_W-1:0]         now_reg,         now_next;
    logic [SLOT_W-1:0]         cur_reg,         cur_next;
    logic [SLOT_W-1:0]         k_reg,           k_next;
    logic [SLOT_W-1:0]         dist_reg,        dist_next;
    logic                      ok_reg,          ok_next;
    logic                      hit_reg,         hit_next;
    logic                      out_valid_reg,   out_valid_next;
    logic                      optimal_hit_reg, optimal_hit_next;
    logic [WAYS_W-1:0]         ways_in_use_reg;

    logic                      ring_we;
    logic [RING_AW-1:0]        ring_waddr;
    entry_t                    ring_wdata;
    logic [RING_AW-1:0]        ring_raddr;
    entry_t                    ring_rdata;

    logic                      ptr_we;
    logic [SET_W-1:0]          ptr_waddr;
    logic [SLOT_W-1:0]         ptr_wdata;
    logic [SET_W-1:0]          ptr_raddr;
    logic [SLOT_W-1:0]         ptr_rdata;

    logic [SET_W-1:0]          set_in_idx;
    logic                      set_in_range;
    logic [WAYS_W-1:0]         eff_limit;
    logic                      occ_ok;
    logic                      addr_match;

    oro_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    oro_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SETS)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (ptr_waddr),
        .wdata (ptr_wdata),
        .raddr (ptr_raddr),
        .rdata (ptr_rdata)
    );

    assign set_in_idx   = SET_W'(set_number);
    assign set_in_range = 32'(set_number) < SETS;
    assign eff_limit    = (32'(ways_in_use_reg) > MAX_WAYS) ? WAYS_W'(MAX_WAYS)
                                                             : ways_in_use_reg;
    assign occ_ok       = 32'(ring_rdata.occ) < 32'(limit_reg);
    assign addr_match   = ring_rdata.valid && (ring_rdata.addr == addr_reg);

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign optimal_hit = optimal_hit_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        set_next         = set_reg;
        addr_next        = addr_reg;
        limit_next       = limit_reg;
        now_next         = now_reg;
        cur_next         = cur_reg;
        k_next           = k_reg;
        dist_next        = dist_reg;
        ok_next          = ok_reg;
        hit_next         = hit_reg;
        out_valid_next   = out_valid_reg;
        optimal_hit_next = optimal_hit_reg;

        ring_we    = 1'b0;
        ring_waddr = ring_index(set_reg, now_reg);
        ring_wdata = '0;
        ring_raddr = ring_index(set_reg, prev_slot(cur_reg));
        ptr_we     = 1'b0;
        ptr_waddr  = set_reg;
        ptr_wdata  = next_slot(now_reg);
        ptr_raddr  = set_in_idx;

        // drop a taken result
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ring_we    = 1'b1;
                ring_waddr = clr_cnt_reg;
                ring_wdata = '0;
                ptr_we     = 32'(clr_cnt_reg) < SETS;
                ptr_waddr  = clr_cnt_reg[SET_W-1:0];
                ptr_wdata  = '0;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = RING_AW'(clr_cnt_reg + RING_AW'(1));
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    set_next   = set_in_idx;
                    addr_next  = line_address;
                    limit_next = eff_limit;
                    if (set_in_range)
                    begin
                        state_next = ST_PTR;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_PTR:
            begin
                now_next   = ptr_rdata;
                cur_next   = prev_slot(ptr_rdata);
                ring_raddr = ring_index(set_reg, prev_slot(ptr_rdata));
                k_next     = SLOT_W'(1);
                ok_next    = 1'b1;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (addr_match)
                begin
                    dist_next = k_reg;
                    if (ok_reg && occ_ok)
                    begin
                        hit_next   = 1'b1;
                        cur_next   = prev_slot(now_reg);
                        ring_raddr = ring_index(set_reg, prev_slot(now_reg));
                        k_next     = SLOT_W'(1);
                        state_next = ST_INC;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    ok_next = ok_reg && occ_ok;
                    if (k_reg == SLOT_LAST)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        k_next   = SLOT_W'(k_reg + SLOT_W'(1));
                        cur_next = prev_slot(cur_reg);
                    end
                end
            end

            ST_INC:
            begin
                ring_we          = 1'b1;
                ring_waddr       = ring_index(set_reg, cur_reg);
                ring_wdata.valid = ring_rdata.valid;
                ring_wdata.occ   = OCC_W'(ring_rdata.occ + OCC_W'(1));
                ring_wdata.addr  = ring_rdata.addr;
                if (k_reg == dist_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next   = SLOT_W'(k_reg + SLOT_W'(1));
                    cur_next = prev_slot(cur_reg);
                end
            end

            ST_FINISH:
            begin
                ring_we          = 1'b1;
                ring_wdata.valid = 1'b1;
                ring_wdata.occ   = '0;
                ring_wdata.addr  = addr_reg;
                ptr_we           = 1'b1;
                state_next       = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    optimal_hit_next = hit_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            optimal_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
            optimal_hit_reg <= optimal_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg   <= set_next;
        addr_reg  <= addr_next;
        limit_reg <= limit_next;
        now_reg   <= now_next;
        cur_reg   <= cur_next;
        k_reg     <= k_next;
        dist_reg  <= dist_next;
        ok_reg    <= ok_next;
        hit_reg   <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_in_use_reg <= WAYS_RESET;
        end
        else if (cfg_we)
        begin
            ways_in_use_reg <= cfg_wdata;
        end
    end

endmodule

### rtl/oro_checker.sv
// ----------------------------------------------------------------------------
// Optimal replacement oracle port checker
// Port-level properties of the oracle, bound to the top level.
// ----------------------------------------------------------------------------
`include "optimal_replacement_oracle_defines.svh"

module oro_checker
    import oro_pkg::*;
#(
    parameter int SETS = SETS_DEFAULT
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [SET_NUMBER_W-1:0] set_number,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    optimal_hit
);

    `ORO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(optimal_hit), "result word changed while stalled")

    `ORO_ASSERT_NEXT(a_one_word, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while a word is in work")

    `ORO_ASSERT_IMPLY(a_bad_set_miss, clk, rst_n, in_valid && in_ready && !out_valid && (32'(set_number) >= SETS), ##2 (out_valid && !optimal_hit), "set out of range did not give a miss")

    `ORO_ASSERT_IMPLY(a_result_from_work, clk, rst_n, $rose(out_valid), $past(!in_ready), "result appeared without work in flight")

endmodule

bind optimal_replacement_oracle oro_checker #(.SETS(SETS)) u_oro_checker (.*);

### tb/optimal_replacement_oracle_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Optimal replacement oracle testbench
// Drives set/address words through a stimulus table and then through reuse
// bursts, a window-edge sweep and noise, under several associativity
// settings (0, 1, 2, 8, 16, 31 and random). A local OPTgen predictor keeps
// its own address rings and occupancy counts, and each returned optimal_hit
// is checked in order, with random stalls on both channels.
// ----------------------------------------------------------------------------
module optimal_replacement_oracle_test;
    import oro_pkg::*;

    localparam int KEEP_WAYS     = -1;
    localparam int NO_CHECK      = -1;
    localparam int PROBE_COUNT   = 20;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 100;
    localparam int WINDOW_PHASE  = 3;
    localparam int PAUSE_PHASE   = 5;
    localparam int HOLD_AT       = 400;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 2 * HISTORY_DEFAULT + 16;

    typedef struct {
        int                        ways;
        logic [SET_NUMBER_W-1:0]   set_id;
        logic [LINE_ADDRESS_W-1:0] addr;
        int                        want;
    } probe_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [SET_NUMBER_W-1:0]   set_number;
    logic [LINE_ADDRESS_W-1:0] line_address;
    logic                      out_valid;
    logic                      out_ready;
    logic                      optimal_hit;
    logic                      cfg_we;
    logic [WAYS_W-1:0]         cfg_wdata;

    int                        slot_ptr [SETS_DEFAULT];
    bit                        ring_live [SETS_DEFAULT][HISTORY_DEFAULT];
    logic [LINE_ADDRESS_W-1:0] ring_addr [SETS_DEFAULT][HISTORY_DEFAULT];
    bit [WAYS_W-1:0]           occupancy [SETS_DEFAULT][HISTORY_DEFAULT];
    logic [WAYS_W-1:0]         ways_cfg = WAYS_RESET;

    bit expected_hits [$];
    bit in_quiet;
    bit out_quiet;
    int mismatch_count;
    int results_checked;
    int words_sent;
    int hits_predicted;
    int settings_used;

    probe_t probe_rows [PROBE_COUNT] = '{
        '{KEEP_WAYS, 6'd0,  64'h0000_0000_0000_0000, 0},
        '{KEEP_WAYS, 6'd0,  64'h0000_0000_0000_0000, 1},
        '{KEEP_WAYS, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 0},
        '{KEEP_WAYS, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1},
        '{KEEP_WAYS, 6'd0,  64'h5555_5555_5555_5555, 0},
        '{KEEP_WAYS, 6'd0,  64'hAAAA_AAAA_AAAA_AAAA, 0},
        '{KEEP_WAYS, 6'd0,  64'h5555_5555_5555_5555, 1},
        '{KEEP_WAYS, 6'd0,  64'h0000_0000_0000_0000, NO_CHECK},
        '{KEEP_WAYS, 6'd1,  64'h8000_0000_0000_0001, 0},
        '{KEEP_WAYS, 6'd1,  64'h8000_0000_0000_0001, 1},
        '{0,         6'd2,  64'h0000_0000_0000_1234, 0},
        '{KEEP_WAYS, 6'd2,  64'h0000_0000_0000_1234, 0},
        '{31,        6'd2,  64'h0000_0000_0000_1234, 1},
        '{1,         6'd3,  64'h0000_0000_0000_FEED, 0},
        '{KEEP_WAYS, 6'd3,  64'h0000_0000_0000_BEEF, 0},
        '{KEEP_WAYS, 6'd3,  64'h0000_0000_0000_FEED, 1},
        '{KEEP_WAYS, 6'd3,  64'h0000_0000_0000_BEEF, NO_CHECK},
        '{16,        6'd4,  64'h0000_0000_0000_0000, 0},
        '{KEEP_WAYS, 6'd4,  64'hFFFF_FFFF_FFFF_FFFE, 0},
        '{KEEP_WAYS, 6'd4,  64'h0000_0000_0000_0000, NO_CHECK}
    };

    optimal_replacement_oracle dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .set_number   (set_number),
        .line_address (line_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .optimal_hit  (optimal_hit),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #30_000_000;
        $display("Timed out waiting for the oracle");
        $display("Mismatches found");
        $finish;
    end

    function automatic bit opt_gen_access(input logic [SET_NUMBER_W-1:0] s,
                                          input logic [LINE_ADDRESS_W-1:0] a);
        int  limit;
        int  now;
        int  reach;
        int  k;
        int  idx;
        bit  fits;
        limit = (ways_cfg > MAX_WAYS_DEFAULT) ? MAX_WAYS_DEFAULT : int'(ways_cfg);
        now = slot_ptr[s];
        occupancy[s][now] = '0;
        reach = 0;
        for (k = 1; k < HISTORY_DEFAULT && reach == 0; k++)
        begin
            idx = (now + HISTORY_DEFAULT - k) % HISTORY_DEFAULT;
            if (ring_live[s][idx] && ring_addr[s][idx] == a)
                reach = k;
        end
        fits = (reach != 0);
        for (k = 1; k <= reach; k++)
            if (occupancy[s][(now + HISTORY_DEFAULT - k) % HISTORY_DEFAULT] >= limit)
                fits = 1'b0;
        if (fits)
            for (k = 1; k <= reach; k++)
            begin
                idx = (now + HISTORY_DEFAULT - k) % HISTORY_DEFAULT;
                occupancy[s][idx] = occupancy[s][idx] + 1'b1;
            end
        ring_live[s][now] = 1'b1;
        ring_addr[s][now] = a;
        slot_ptr[s] = (now + 1) % HISTORY_DEFAULT;
        return fits;
    endfunction

    function automatic logic [LINE_ADDRESS_W-1:0] fresh_address();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic [SET_NUMBER_W-1:0] s,
                             input logic [LINE_ADDRESS_W-1:0] a, input int want);
        int gap;
        bit predicted;
        gap = in_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        set_number   <= s;
        line_address <= a;
        do @(posedge clk); while (in_ready !== 1'b1);
        predicted = opt_gen_access(s, a);
        expected_hits.push_back((want == NO_CHECK) ? predicted : want[0]);
        words_sent++;
        if (predicted)
            hits_predicted++;
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge clk);
    endtask

    task automatic set_ways(input logic [WAYS_W-1:0] v);
        drain_words();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        ways_cfg = v;
        settings_used++;
    endtask

    initial
    begin : result_side
        int gap;
        bit hold_done;
        bit want_hit;
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            gap = out_quiet ? 0 : $urandom_range(0, 7);
            if (results_checked == HOLD_AT && !hold_done)
            begin
                gap = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (expected_hits.size() == 0)
            begin
                $error("optimal_hit: result with no word outstanding, actual %0b",
                       optimal_hit);
                mismatch_count++;
            end
            else
            begin
                want_hit = expected_hits.pop_front();
                if (optimal_hit !== want_hit)
                begin
                    $error("optimal_hit: expected %0b, actual %0b", want_hit, optimal_hit);
                    mismatch_count++;
                end
            end
            results_checked++;
            if (results_checked % 40 == 0)
                out_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : word_side
        int                        r;
        int                        phase;
        int                        phase_words;
        int                        pool_size;
        int                        run;
        int                        i;
        int                        ways_plan [PHASES];
        bit                        paused;
        logic [SET_NUMBER_W-1:0]   focus;
        logic [SET_NUMBER_W-1:0]   s;
        logic [LINE_ADDRESS_W-1:0] anchor;
        logic [LINE_ADDRESS_W-1:0] pool [12];
        in_valid     = 1'b0;
        set_number   = '0;
        line_address = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_quiet     = 1'b0;
        paused       = 1'b0;
        ways_plan    = '{1, 0, 31, 16, 2, 8, 0, 0, 0, 16};
        while (rst_n !== 1'b1) @(posedge clk);

        for (r = 0; r < PROBE_COUNT; r++)
        begin
            if (probe_rows[r].ways != KEEP_WAYS)
                set_ways(WAYS_W'(probe_rows[r].ways));
            send_word(probe_rows[r].set_id, probe_rows[r].addr, probe_rows[r].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase >= 6 && phase <= 8)
                set_ways(WAYS_W'($urandom_range(0, 31)));
            else
                set_ways(WAYS_W'(ways_plan[phase]));

            // sweep the window edge: reuse at distance HISTORY-1, then at HISTORY
            if (phase == WINDOW_PHASE)
            begin
                focus  = SET_NUMBER_W'($urandom_range(0, SETS_DEFAULT - 1));
                anchor = {$urandom, $urandom};
                send_word(focus, anchor, NO_CHECK);
                for (i = 0; i < HISTORY_DEFAULT - 2; i++)
                    send_word(focus, {$urandom, $urandom}, NO_CHECK);
                send_word(focus, anchor, NO_CHECK);
                for (i = 0; i < HISTORY_DEFAULT - 1; i++)
                    send_word(focus, {$urandom, $urandom}, NO_CHECK);
                send_word(focus, anchor, NO_CHECK);
            end

            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                in_quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) < 8)
                begin
                    focus     = SET_NUMBER_W'($urandom_range(0, SETS_DEFAULT - 1));
                    pool_size = $urandom_range(2, 12);
                    for (i = 0; i < pool_size; i++)
                        pool[i] = fresh_address();
                    run = $urandom_range(8, 24);
                    for (i = 0; i < run; i++)
                    begin
                        s = ($urandom_range(0, 7) == 0)
                            ? SET_NUMBER_W'($urandom_range(0, SETS_DEFAULT - 1))
                            : focus;
                        send_word(s, pool[$urandom_range(0, pool_size - 1)], NO_CHECK);
                    end
                    phase_words += run;
                end
                else
                begin
                    send_word(SET_NUMBER_W'($urandom_range(0, SETS_DEFAULT - 1)),
                              fresh_address(), NO_CHECK);
                    phase_words++;
                end
                if (phase == PAUSE_PHASE && !paused && phase_words >= PHASE_WORDS / 2)
                begin
                    drain_words();
                    paused = 1'b1;
                end
            end
        end

        drain_words();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d oracle results from %0d words, %0d of them predicted hits,",
                 results_checked, words_sent, hits_predicted);
        $display("across %0d associativity writes including 0, 1, 16 and 31.", settings_used);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
